[design/pdfh_pkg.sv]
// ----------------------------------------------------------------------------
// pdfh_pkg
// Shared types, constants and instruction decode for the pipelined decode
// stage with forwarding and hazard detection.
// ----------------------------------------------------------------------------
package pdfh_pkg;

  localparam int unsigned NUM_REGS   = 15;
  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned REG_ID_W   = 4;
  localparam int unsigned ICODE_W    = 4;
  localparam int unsigned RF_AW      = $clog2(NUM_REGS);

  typedef logic [REG_ID_W-1:0]   reg_id_t;
  typedef logic [ICODE_W-1:0]    icode_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  // Y86-64 icodes (codes 0, 1, 7 and 12..15 decode to nothing)
  localparam icode_t IC_NOP   = 4'd1;
  localparam icode_t IC_RRMOV = 4'd2;
  localparam icode_t IC_IRMOV = 4'd3;
  localparam icode_t IC_RMMOV = 4'd4;
  localparam icode_t IC_MRMOV = 4'd5;
  localparam icode_t IC_OP    = 4'd6;
  localparam icode_t IC_JXX   = 4'd7;
  localparam icode_t IC_CALL  = 4'd8;
  localparam icode_t IC_RET   = 4'd9;
  localparam icode_t IC_PUSH  = 4'd10;
  localparam icode_t IC_POP   = 4'd11;

  localparam reg_id_t REG_SP   = 4'd4;
  localparam reg_id_t REG_NONE = 4'd15;

  typedef struct packed {
    reg_id_t src_a;
    reg_id_t src_b;
    reg_id_t dest_e;
    reg_id_t dest_m;
  } dec_t;

  // where a register file operand comes from once the read data is back
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_BANK_E,
    RD_BANK_M,
    RD_BYPASS
  } rd_src_e;

  function automatic dec_t decode(icode_t ic, reg_id_t ra, reg_id_t rb);
    dec_t d;
    d = '{src_a: REG_NONE, src_b: REG_NONE, dest_e: REG_NONE, dest_m: REG_NONE};
    unique case (ic)
      IC_RRMOV: begin
        d.src_a  = ra;
        d.dest_e = rb;
      end
      IC_IRMOV: begin
        d.dest_e = rb;
      end
      IC_RMMOV: begin
        d.src_a = ra;
        d.src_b = rb;
      end
      IC_MRMOV: begin
        d.src_b  = rb;
        d.dest_m = ra;
      end
      IC_OP: begin
        d.src_a  = ra;
        d.src_b  = rb;
        d.dest_e = rb;
      end
      IC_CALL: begin
        d.src_b  = REG_SP;
        d.dest_e = REG_SP;
      end
      IC_RET: begin
        d.src_a  = REG_SP;
        d.src_b  = REG_SP;
        d.dest_e = REG_SP;
      end
      IC_PUSH: begin
        d.src_a  = ra;
        d.src_b  = REG_SP;
        d.dest_e = REG_SP;
      end
      IC_POP: begin
        d.src_a  = REG_SP;
        d.src_b  = REG_SP;
        d.dest_e = REG_SP;
        d.dest_m = ra;
      end
      default: begin
      end
    endcase
    return d;
  endfunction

  // true when the id names an entry that the register file holds
  function automatic logic in_file(reg_id_t id);
    return id < REG_ID_W'(NUM_REGS);
  endfunction

endpackage

[design/pdfh_ram.sv]
// ----------------------------------------------------------------------------
// pdfh_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module pdfh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[design/pipelined_decode_forward_hazard.sv]
// ----------------------------------------------------------------------------
// pipelined_decode_forward_hazard
// Y86-64 decode stage: source/destination select, operand forwarding,
// load-use / mispredict bubble, and register file writeback.
// ----------------------------------------------------------------------------
// One word per clock cycle while out_stall_i does not hold the output; a word
// passes two registers (input register, then result register) on its way to
// the output. When a word is accepted it is decoded and its register file
// reads are issued to the two RAM banks at once, so the operands are back
// when the word sits in the input register. The word is then forwarded and
// checked for a bubble in one pass as it moves into the result register; at
// that same edge the writeback of wb_alu_value / wb_load_value happens and
// the kept destination ids advance one stage. in_stall_o follows out_stall_i
// in the same cycle when both registers are full. The register file reads as
// zero after reset with no clearing pass: each entry carries a written bit.
// ----------------------------------------------------------------------------
module pipelined_decode_forward_hazard (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  pdfh_pkg::icode_t         instr_code_i,
  input  pdfh_pkg::reg_id_t        reg_a_i,
  input  pdfh_pkg::reg_id_t        reg_b_i,
  input  pdfh_pkg::word_t          next_pc_i,
  input  pdfh_pkg::reg_id_t        exec_dest_e_i,
  input  pdfh_pkg::word_t          exec_value_i,
  input  pdfh_pkg::word_t          mem_alu_value_i,
  input  pdfh_pkg::word_t          mem_load_value_i,
  input  pdfh_pkg::word_t          wb_alu_value_i,
  input  pdfh_pkg::word_t          wb_load_value_i,
  input  logic                     exec_cond_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output pdfh_pkg::reg_id_t        src_a_o,
  output pdfh_pkg::reg_id_t        src_b_o,
  output pdfh_pkg::reg_id_t        dest_e_o,
  output pdfh_pkg::reg_id_t        dest_m_o,
  output pdfh_pkg::word_t          value_a_o,
  output pdfh_pkg::word_t          value_b_o,
  output logic                     insert_bubble_o
);

  import pdfh_pkg::*;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_vld_q;
  logic out_vld_q;
  logic acc;   // word taken into the input register
  logic adv;   // word moves from input register to result register

  assign adv        = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !adv;
  assign acc        = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Input register payload
  // --------------------------------------------------------------------------
  icode_t  s1_ic_q;
  dec_t    s1_dec_q;
  word_t   s1_next_pc_q;
  reg_id_t s1_exec_dest_e_q;
  word_t   s1_exec_value_q;
  word_t   s1_mem_alu_q;
  word_t   s1_mem_load_q;
  word_t   s1_wb_alu_q;
  word_t   s1_wb_load_q;
  logic    s1_exec_cond_q;
  rd_src_e rd_src_q [2];
  word_t   byp_q    [2];

  // --------------------------------------------------------------------------
  // Kept pipeline state
  // --------------------------------------------------------------------------
  icode_t  ex_ic_q;
  reg_id_t ex_dest_m_q;
  reg_id_t mem_dest_e_q;
  reg_id_t mem_dest_m_q;
  reg_id_t wb_dest_e_q;
  reg_id_t wb_dest_m_q;

  // Register file: bank E holds ALU writebacks, bank M load writebacks.
  // rf_sel_q says which bank wrote an entry last, rf_vld_q that it was written.
  logic [NUM_REGS-1:0] rf_vld_q;
  logic [NUM_REGS-1:0] rf_sel_q;

  // --------------------------------------------------------------------------
  // Writeback (happens as the word in the input register advances)
  // --------------------------------------------------------------------------
  logic             we_e;
  logic             we_m;
  logic [RF_AW-1:0] wa_e;
  logic [RF_AW-1:0] wa_m;
  logic [NUM_REGS-1:0] rf_vld_d;
  logic [NUM_REGS-1:0] rf_sel_d;

  assign we_e = adv && in_file(wb_dest_e_q);
  assign we_m = adv && in_file(wb_dest_m_q);
  assign wa_e = wb_dest_e_q[RF_AW-1:0];
  assign wa_m = wb_dest_m_q[RF_AW-1:0];

  // load port wins when both name the same register
  always_comb begin
    rf_vld_d = rf_vld_q;
    rf_sel_d = rf_sel_q;
    if (we_e) begin
      rf_vld_d[wa_e] = 1'b1;
      rf_sel_d[wa_e] = 1'b0;
    end
    if (we_m) begin
      rf_vld_d[wa_m] = 1'b1;
      rf_sel_d[wa_m] = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Register file read issue at acceptance
  // --------------------------------------------------------------------------
  dec_t             in_dec;
  reg_id_t          rd_id    [2];
  logic [RF_AW-1:0] rd_addr  [2];
  rd_src_e          rd_src_d [2];
  word_t            byp_d    [2];

  assign in_dec   = decode(instr_code_i, reg_a_i, reg_b_i);
  assign rd_id[0] = in_dec.src_a;
  assign rd_id[1] = in_dec.src_b;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      rd_addr[p]  = in_file(rd_id[p]) ? rd_id[p][RF_AW-1:0] : '0;
      byp_d[p]    = s1_wb_load_q;
      rd_src_d[p] = RD_ZERO;
      // a write at this same edge is not seen by the RAM read: take it here
      priority if (!in_file(rd_id[p])) begin
        rd_src_d[p] = RD_ZERO;
      end else if (we_m && wb_dest_m_q == rd_id[p]) begin
        rd_src_d[p] = RD_BYPASS;
        byp_d[p]    = s1_wb_load_q;
      end else if (we_e && wb_dest_e_q == rd_id[p]) begin
        rd_src_d[p] = RD_BYPASS;
        byp_d[p]    = s1_wb_alu_q;
      end else if (!rf_vld_q[rd_addr[p]]) begin
        rd_src_d[p] = RD_ZERO;
      end else if (rf_sel_q[rd_addr[p]]) begin
        rd_src_d[p] = RD_BANK_M;
      end else begin
        rd_src_d[p] = RD_BANK_E;
      end
    end
  end

  word_t bank_e_rd [2];
  word_t bank_m_rd [2];

  pdfh_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_bank_e (
    .clk_i     (clk_i),
    .we_i      (we_e),
    .waddr_i   (wa_e),
    .wdata_i   (s1_wb_alu_q),
    .re_i      (acc),
    .raddr_a_i (rd_addr[0]),
    .raddr_b_i (rd_addr[1]),
    .rdata_a_o (bank_e_rd[0]),
    .rdata_b_o (bank_e_rd[1])
  );

  pdfh_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_bank_m (
    .clk_i     (clk_i),
    .we_i      (we_m),
    .waddr_i   (wa_m),
    .wdata_i   (s1_wb_load_q),
    .re_i      (acc),
    .raddr_a_i (rd_addr[0]),
    .raddr_b_i (rd_addr[1]),
    .rdata_a_o (bank_m_rd[0]),
    .rdata_b_o (bank_m_rd[1])
  );

  // --------------------------------------------------------------------------
  // Forwarding and hazard check on the word in the input register
  // --------------------------------------------------------------------------
  reg_id_t s1_src  [2];
  word_t   rf_val  [2];
  word_t   fwd_val [2];
  word_t   value_a_d;
  logic    bubble_d;

  assign s1_src[0] = s1_dec_q.src_a;
  assign s1_src[1] = s1_dec_q.src_b;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      unique case (rd_src_q[p])
        RD_ZERO:   rf_val[p] = '0;
        RD_BANK_E: rf_val[p] = bank_e_rd[p];
        RD_BANK_M: rf_val[p] = bank_m_rd[p];
        RD_BYPASS: rf_val[p] = byp_q[p];
        default:   rf_val[p] = '0;
      endcase
      // priority: execute, memory load, memory ALU, writeback load, writeback ALU
      priority if (s1_src[p] == REG_NONE) begin
        fwd_val[p] = '0;
      end else if (s1_src[p] == s1_exec_dest_e_q) begin
        fwd_val[p] = s1_exec_value_q;
      end else if (s1_src[p] == mem_dest_m_q) begin
        fwd_val[p] = s1_mem_load_q;
      end else if (s1_src[p] == mem_dest_e_q) begin
        fwd_val[p] = s1_mem_alu_q;
      end else if (s1_src[p] == wb_dest_m_q) begin
        fwd_val[p] = s1_wb_load_q;
      end else if (s1_src[p] == wb_dest_e_q) begin
        fwd_val[p] = s1_wb_alu_q;
      end else begin
        fwd_val[p] = rf_val[p];
      end
    end
  end

  assign value_a_d = (s1_ic_q == IC_CALL || s1_ic_q == IC_JXX) ? s1_next_pc_q : fwd_val[0];

  // load-use on either source, or a jump resolved not taken
  assign bubble_d = ((ex_ic_q == IC_MRMOV || ex_ic_q == IC_POP) &&
                     (ex_dest_m_q == s1_dec_q.src_a || ex_dest_m_q == s1_dec_q.src_b)) ||
                    (ex_ic_q == IC_JXX && !s1_exec_cond_q);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      ex_ic_q      <= IC_NOP;
      ex_dest_m_q  <= REG_NONE;
      mem_dest_e_q <= REG_NONE;
      mem_dest_m_q <= REG_NONE;
      wb_dest_e_q  <= REG_NONE;
      wb_dest_m_q  <= REG_NONE;
      rf_vld_q     <= '0;
      rf_sel_q     <= '0;
    end else begin
      if (acc) begin
        s1_vld_q <= 1'b1;
      end else if (adv) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (adv) begin
        wb_dest_e_q  <= mem_dest_e_q;
        wb_dest_m_q  <= mem_dest_m_q;
        mem_dest_e_q <= s1_exec_dest_e_q;
        mem_dest_m_q <= ex_dest_m_q;
        ex_ic_q      <= bubble_d ? IC_NOP : s1_ic_q;
        ex_dest_m_q  <= bubble_d ? REG_NONE : s1_dec_q.dest_m;
      end
      rf_vld_q <= rf_vld_d;
      rf_sel_q <= rf_sel_d;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  reg_id_t src_a_q;
  reg_id_t src_b_q;
  reg_id_t dest_e_q;
  reg_id_t dest_m_q;
  word_t   value_a_q;
  word_t   value_b_q;
  logic    bubble_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ic_q          <= instr_code_i;
      s1_dec_q         <= in_dec;
      s1_next_pc_q     <= next_pc_i;
      s1_exec_dest_e_q <= exec_dest_e_i;
      s1_exec_value_q  <= exec_value_i;
      s1_mem_alu_q     <= mem_alu_value_i;
      s1_mem_load_q    <= mem_load_value_i;
      s1_wb_alu_q      <= wb_alu_value_i;
      s1_wb_load_q     <= wb_load_value_i;
      s1_exec_cond_q   <= exec_cond_i;
      rd_src_q         <= rd_src_d;
      byp_q            <= byp_d;
    end
    if (adv) begin
      src_a_q   <= s1_dec_q.src_a;
      src_b_q   <= s1_dec_q.src_b;
      dest_e_q  <= s1_dec_q.dest_e;
      dest_m_q  <= s1_dec_q.dest_m;
      value_a_q <= value_a_d;
      value_b_q <= fwd_val[1];
      bubble_q  <= bubble_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign src_a_o         = src_a_q;
  assign src_b_o         = src_b_q;
  assign dest_e_o        = dest_e_q;
  assign dest_m_o        = dest_m_q;
  assign value_a_o       = value_a_q;
  assign value_b_o       = value_b_q;
  assign insert_bubble_o = bubble_q;

`ifndef SYNTHESIS
  // a bubble leaves a nop with no destination in execute
  a_bubble_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && bubble_d |=> ex_ic_q == IC_NOP && ex_dest_m_q == REG_NONE)
    else $error("bubble did not clear execute state");

  // a load writeback marks the entry as held in bank M
  a_load_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_m |=> rf_sel_q[$past(wa_m)] && rf_vld_q[$past(wa_m)])
    else $error("load writeback not recorded");

  // the input register never drops a word that cannot advance
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !adv |=> s1_vld_q && $stable(s1_dec_q))
    else $error("held word lost from input register");

  // the input side stalls only while the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without a full, stalled output");
`endif

endmodule
